// ===== src/ptt_pkg.sv =====
`default_nettype none

package ptt_pkg;

    localparam int MAX_PARTS = 128;
    localparam int IDX_W     = $clog2(MAX_PARTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int PIDX_W    = 7;
    localparam int CMP_W     = (CNT_W > PIDX_W) ? CNT_W : PIDX_W;
    localparam int LBA_W     = 64;

    // MBR partition type bytes.
    localparam logic [7:0] MBR_EMPTY     = 8'h00;
    localparam logic [7:0] MBR_ESP       = 8'hEF;
    localparam logic [7:0] MBR_NATIVE_FS = 8'h83;
    localparam logic [7:0] MBR_NTFS      = 8'h07;
    localparam logic [7:0] MBR_FAT32     = 8'h0B;
    localparam logic [7:0] MBR_FAT32_LBA = 8'h0C;

    // GPT type GUIDs, byte 0 in bits 7:0 of the low word.
    localparam logic [63:0] ESP_GUID_LO       = 64'h11D2F81FC12A7328;
    localparam logic [63:0] ESP_GUID_HI       = 64'h3BC93EC9A0004BBA;
    localparam logic [63:0] BDATA_GUID_LO     = 64'h4433B9E5EBD0A0A2;
    localparam logic [63:0] BDATA_GUID_HI     = 64'hC79926B7B668C087;
    localparam logic [63:0] NATIVE_FS_GUID_LO = 64'h477284830FC63DAF;
    localparam logic [63:0] NATIVE_FS_GUID_HI = 64'hE47D47D8693D798E;

    typedef enum logic [1:0] {
        REQ_CLEAR     = 2'd0,
        REQ_LOAD_MBR  = 2'd1,
        REQ_LOAD_GPT  = 2'd2,
        REQ_TRANSLATE = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } fsm_t;

    typedef struct packed {
        logic             empty;
        logic             esp;
        logic             fmt;
        logic [LBA_W-1:0] first;
        logic [LBA_W-1:0] last;
    } cls_t;

    typedef struct packed {
        logic [LBA_W-1:0] first;
        logic [LBA_W-1:0] last;
        logic             esp;
        logic             fmt;
    } entry_t;

endpackage

`default_nettype wire

// ===== src/ptt_req_if.sv =====
`default_nettype none

interface ptt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  type_code;
    logic [63:0] guid_low;
    logic [63:0] guid_high;
    logic [63:0] start_lba;
    logic [63:0] end_or_count;
    logic [6:0]  part_index;
    logic [63:0] sector;

    modport source (
        output valid, req_type, type_code, guid_low, guid_high, start_lba,
               end_or_count, part_index, sector,
        input  ready
    );

    modport sink (
        input  valid, req_type, type_code, guid_low, guid_high, start_lba,
               end_or_count, part_index, sector,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/ptt_rsp_if.sv =====
`default_nettype none

interface ptt_rsp_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [63:0]       abs_lba;
    logic [7:0]        part_count;
    logic              is_esp;
    logic              is_formatted;
    logic signed [7:0] esp_index;

    modport source (
        output valid, status, abs_lba, part_count, is_esp, is_formatted, esp_index,
        input  ready
    );

    modport sink (
        input  valid, status, abs_lba, part_count, is_esp, is_formatted, esp_index,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/ptt_classify.sv =====
`default_nettype none

module ptt_classify (
    input  ptt_pkg::req_type_t req_type,
    input  logic [7:0]         type_code,
    input  logic [63:0]        guid_low,
    input  logic [63:0]        guid_high,
    input  logic [63:0]        start_lba,
    input  logic [63:0]        end_or_count,
    output ptt_pkg::cls_t      cls
);
    import ptt_pkg::*;

    logic [31:0] mbr_last;
    logic        guid_esp;
    logic        guid_bdata;
    logic        guid_native;

    // MBR entries give a sector count; the end wraps in 32 bits.
    assign mbr_last    = start_lba[31:0] + end_or_count[31:0] - 32'd1;
    assign guid_esp    = (guid_low == ESP_GUID_LO) && (guid_high == ESP_GUID_HI);
    assign guid_bdata  = (guid_low == BDATA_GUID_LO) && (guid_high == BDATA_GUID_HI);
    assign guid_native = (guid_low == NATIVE_FS_GUID_LO) && (guid_high == NATIVE_FS_GUID_HI);

    always_comb
    begin
        if (req_type == REQ_LOAD_MBR)
        begin
            cls.empty = (type_code == MBR_EMPTY);
            cls.esp   = (type_code == MBR_ESP);
            cls.fmt   = (type_code == MBR_NATIVE_FS) || (type_code == MBR_NTFS) ||
                        (type_code == MBR_FAT32) || (type_code == MBR_FAT32_LBA) ||
                        (type_code == MBR_ESP);
            cls.first = {32'd0, start_lba[31:0]};
            cls.last  = {32'd0, mbr_last};
        end
        else
        begin
            cls.empty = (guid_low == 64'd0) && (guid_high == 64'd0);
            cls.esp   = guid_esp;
            cls.fmt   = guid_esp || guid_bdata || guid_native;
            cls.first = start_lba;
            cls.last  = end_or_count;
        end
    end

endmodule

`default_nettype wire

// ===== src/partition_table_translate_top.sv =====
// Partition table builder and sector translator. Each request item (clear, MBR
// entry load, GPT entry load or translate) yields exactly one result item. An
// item passes through the synchronous read of the 128-entry table memory, then
// the table write or the span and sum adders, and then the range compare into
// the output register. The next item is accepted in the cycle after the
// previous one leaves the finish stage, so the block takes no new item while
// one is still in the execute or finish step. A result that waits in the
// output register does not stop the next item from being accepted. Table
// entries at or beyond the entry count may be read but are never used, so the
// memory has no clearing pass after reset or clear.
`default_nettype none

module partition_table_translate_top (
    input  wire        clk,
    input  wire        rst_n,
    ptt_req_if.sink    req,
    ptt_rsp_if.source  rsp
);
    import ptt_pkg::*;

    fsm_t state_reg;
    fsm_t state_next;
    logic in_take;
    logic exec_en;
    logic fin_en;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic signed [IDX_W:0]   first_esp_reg;
    logic signed [IDX_W:0]   first_esp_next;

    req_type_t          rq_type_reg;
    logic [7:0]         rq_code_reg;
    logic [63:0]        rq_glo_reg;
    logic [63:0]        rq_ghi_reg;
    logic [LBA_W-1:0]   rq_start_reg;
    logic [LBA_W-1:0]   rq_end_reg;
    logic [PIDX_W-1:0]  rq_idx_reg;
    logic [LBA_W-1:0]   rq_sect_reg;

    entry_t             table_mem [MAX_PARTS];
    entry_t             rd_entry_reg;
    entry_t             wr_entry;
    logic               mem_we;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;

    cls_t               cls;

    status_t            ex_status_d;
    logic               ex_esp_d;
    logic               ex_fmt_d;
    logic               ex_xlate_d;
    logic               ex_bad_d;
    logic               full;
    logic               idx_bad;

    status_t            ex_status_reg;
    logic               ex_esp_reg;
    logic               ex_fmt_reg;
    logic               ex_xlate_reg;
    logic               ex_bad_reg;
    logic [LBA_W-1:0]   ex_sum_reg;
    logic [LBA_W-1:0]   ex_span_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            out_status_reg;
    logic [LBA_W-1:0]   out_lba_reg;
    logic [7:0]         out_count_reg;
    logic               out_esp_reg;
    logic               out_fmt_reg;
    logic signed [7:0]  out_espidx_reg;
    logic               range_err;

    ptt_classify u_classify (
        .req_type     (rq_type_reg),
        .type_code    (rq_code_reg),
        .guid_low     (rq_glo_reg),
        .guid_high    (rq_ghi_reg),
        .start_lba    (rq_start_reg),
        .end_or_count (rq_end_reg),
        .cls          (cls)
    );

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = (state_reg == S_IDLE);
        in_take   = (state_reg == S_IDLE) && req.valid;
        exec_en   = (state_reg == S_EXEC);
        fin_en    = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            first_esp_reg <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            first_esp_reg <= first_esp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- request capture and table read ----------------
    assign rd_addr = IDX_W'(req.part_index);

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rq_type_reg  <= req_type_t'(req.req_type);
            rq_code_reg  <= req.type_code;
            rq_glo_reg   <= req.guid_low;
            rq_ghi_reg   <= req.guid_high;
            rq_start_reg <= req.start_lba;
            rq_end_reg   <= req.end_or_count;
            rq_idx_reg   <= req.part_index;
            rq_sect_reg  <= req.sector;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[wr_addr] <= wr_entry;
        if (in_take)
            rd_entry_reg <= table_mem[rd_addr];
    end

    // ---------------- execute: table clear, write or lookup ----------------
    assign full    = (count_reg == CNT_W'(MAX_PARTS));
    assign idx_bad = (CMP_W'(rq_idx_reg) >= CMP_W'(count_reg));
    assign wr_addr = count_reg[IDX_W-1:0];

    always_comb
    begin
        wr_entry.first = cls.first;
        wr_entry.last  = cls.last;
        wr_entry.esp   = cls.esp;
        wr_entry.fmt   = cls.fmt;
    end

    always_comb
    begin
        count_next     = count_reg;
        first_esp_next = first_esp_reg;
        mem_we         = 1'b0;
        ex_status_d    = STAT_DONE;
        ex_esp_d       = 1'b0;
        ex_fmt_d       = 1'b0;
        ex_xlate_d     = 1'b0;
        ex_bad_d       = 1'b0;
        if (exec_en)
        begin
            unique case (rq_type_reg)
                REQ_CLEAR:
                begin
                    count_next     = '0;
                    first_esp_next = '1;
                end
                REQ_LOAD_MBR, REQ_LOAD_GPT:
                begin
                    if (cls.empty)
                        ex_status_d = STAT_EMPTY;
                    else if (full)
                        ex_status_d = STAT_FULL;
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        ex_esp_d   = cls.esp;
                        ex_fmt_d   = cls.fmt;
                        if (cls.esp && first_esp_reg[IDX_W])
                            first_esp_next = {1'b0, count_reg[IDX_W-1:0]};
                    end
                end
                REQ_TRANSLATE:
                begin
                    if (idx_bad)
                        ex_bad_d = 1'b1;
                    else
                    begin
                        ex_xlate_d = 1'b1;
                        ex_esp_d   = rd_entry_reg.esp;
                        ex_fmt_d   = rd_entry_reg.fmt;
                    end
                end
                default:
                begin
                    ex_status_d = STAT_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_en)
        begin
            ex_status_reg <= ex_status_d;
            ex_esp_reg    <= ex_esp_d;
            ex_fmt_reg    <= ex_fmt_d;
            ex_xlate_reg  <= ex_xlate_d;
            ex_bad_reg    <= ex_bad_d;
            ex_span_reg   <= rd_entry_reg.last - rd_entry_reg.first;
            ex_sum_reg    <= rd_entry_reg.first + rq_sect_reg;
        end
    end

    // ---------------- finish: range check and output register ----------------
    assign range_err = ex_bad_reg || (ex_xlate_reg && (rq_sect_reg > ex_span_reg));

    always_comb
    begin
        if (fin_en)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fin_en)
        begin
            out_status_reg <= range_err ? STAT_RANGE : ex_status_reg;
            if (range_err)
                out_lba_reg <= '1;
            else if (ex_xlate_reg)
                out_lba_reg <= ex_sum_reg;
            else
                out_lba_reg <= '0;
            out_count_reg  <= 8'(count_reg);
            out_esp_reg    <= ex_esp_reg;
            out_fmt_reg    <= ex_fmt_reg;
            out_espidx_reg <= 8'(first_esp_reg);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.abs_lba      = out_lba_reg;
    assign rsp.part_count   = out_count_reg;
    assign rsp.is_esp       = out_esp_reg;
    assign rsp.is_formatted = out_fmt_reg;
    assign rsp.esp_index    = out_espidx_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PARTS))
        else $error("entry count exceeds table size");

    a_write_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (count_reg < CNT_W'(MAX_PARTS)))
        else $error("table write into a full table");

    a_esp_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        first_esp_reg[IDX_W] || ({1'b0, first_esp_reg[IDX_W-1:0]} < count_reg))
        else $error("first ESP index not below entry count");

    a_exec_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> (state_reg == S_FINISH))
        else $error("execute stage did not advance to finish");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result item raised outside the finish stage");
`endif

endmodule

`default_nettype wire

// ===== tb/partition_table_translate_top_tb.sv =====
`timescale 1ns / 100ps

module partition_table_translate_top_tb;

    import ptt_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 9;
    localparam int RANDOM_STOP = 910;
    localparam int HOLD_LEN    = 80;
    localparam int TAIL_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        req_type_t   req_type;
        logic [7:0]  type_code;
        logic [63:0] guid_low;
        logic [63:0] guid_high;
        logic [63:0] start_lba;
        logic [63:0] end_or_count;
        logic [6:0]  part_index;
        logic [63:0] sector;
    } ptt_request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] abs_lba;
        logic [7:0]  part_count;
        logic        is_esp;
        logic        is_formatted;
        logic [7:0]  esp_index;
    } ptt_result_t;

    // Keeps its own copy of the partition table and the results it implies.
    class partition_scoreboard;
        logic [63:0] first_tab[MAX_PARTS];
        logic [63:0] last_tab[MAX_PARTS];
        bit          esp_tab[MAX_PARTS];
        bit          fmt_tab[MAX_PARTS];
        int          entries = 0;
        int          first_esp = -1;
        ptt_result_t pending[$];
        int          errors = 0;

        function void store_entry(inout ptt_result_t res, input logic [63:0] first,
                                  input logic [63:0] last, input bit esp, input bit fmt);
            if (entries >= MAX_PARTS) begin
                res.status = STAT_FULL;
                return;
            end
            first_tab[entries] = first;
            last_tab[entries]  = last;
            esp_tab[entries]   = esp;
            fmt_tab[entries]   = fmt;
            if (esp && first_esp < 0)
                first_esp = entries;
            entries++;
            res.is_esp       = esp;
            res.is_formatted = fmt;
        endfunction

        function void note_request(ptt_request_t r);
            ptt_result_t res;
            logic [31:0] s32;
            logic [31:0] l32;
            logic [63:0] span;
            bit          esp;
            bit          fmt;
            res = '0;
            res.status = STAT_DONE;
            case (r.req_type)
                REQ_CLEAR:
                begin
                    entries   = 0;
                    first_esp = -1;
                end
                REQ_LOAD_MBR:
                begin
                    if (r.type_code == MBR_EMPTY)
                        res.status = STAT_EMPTY;
                    else
                    begin
                        // The end is formed in 32 bits and may wrap.
                        s32 = r.start_lba[31:0];
                        l32 = s32 + r.end_or_count[31:0] - 32'd1;
                        esp = (r.type_code == MBR_ESP);
                        fmt = esp || r.type_code == MBR_NATIVE_FS || r.type_code == MBR_NTFS
                              || r.type_code == MBR_FAT32 || r.type_code == MBR_FAT32_LBA;
                        store_entry(res, {32'h0, s32}, {32'h0, l32}, esp, fmt);
                    end
                end
                REQ_LOAD_GPT:
                begin
                    if (r.guid_low == 64'h0 && r.guid_high == 64'h0)
                        res.status = STAT_EMPTY;
                    else
                    begin
                        esp = (r.guid_low == ESP_GUID_LO && r.guid_high == ESP_GUID_HI);
                        fmt = esp
                              || (r.guid_low == BDATA_GUID_LO && r.guid_high == BDATA_GUID_HI)
                              || (r.guid_low == NATIVE_FS_GUID_LO
                                  && r.guid_high == NATIVE_FS_GUID_HI);
                        store_entry(res, r.start_lba, r.end_or_count, esp, fmt);
                    end
                end
                default:
                begin
                    if (int'(r.part_index) >= entries)
                    begin
                        res.status  = STAT_RANGE;
                        res.abs_lba = '1;
                    end
                    else
                    begin
                        span = last_tab[r.part_index] - first_tab[r.part_index];
                        res.is_esp       = esp_tab[r.part_index];
                        res.is_formatted = fmt_tab[r.part_index];
                        if (r.sector > span)
                        begin
                            res.status  = STAT_RANGE;
                            res.abs_lba = '1;
                        end
                        else
                            res.abs_lba = first_tab[r.part_index] + r.sector;
                    end
                end
            endcase
            res.part_count = entries[7:0];
            res.esp_index  = first_esp[7:0];
            pending.push_back(res);
        endfunction

        function void check_result(ptt_result_t got);
            ptt_result_t want;
            if (pending.size() == 0)
            begin
                $error("result item arrived with no request outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.abs_lba !== want.abs_lba)
            begin
                $error("abs_lba: expected %h, got %h", want.abs_lba, got.abs_lba);
                errors++;
            end
            if (got.part_count !== want.part_count)
            begin
                $error("part_count: expected %0d, got %0d", want.part_count, got.part_count);
                errors++;
            end
            if (got.is_esp !== want.is_esp)
            begin
                $error("is_esp: expected %0d, got %0d", want.is_esp, got.is_esp);
                errors++;
            end
            if (got.is_formatted !== want.is_formatted)
            begin
                $error("is_formatted: expected %0d, got %0d",
                       want.is_formatted, got.is_formatted);
                errors++;
            end
            if (got.esp_index !== want.esp_index)
            begin
                $error("esp_index: expected %0d, got %0d",
                       $signed(want.esp_index), $signed(got.esp_index));
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ptt_req_if req_ch();
    ptt_rsp_if rsp_ch();

    partition_table_translate_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    partition_scoreboard sb;
    ptt_result_t         rsp_seen;
    int                  items_sent  = 0;
    int                  tx_idle_pct = 18;
    int                  rx_idle_pct = 73;
    int                  hold_left   = 0;
    int                  hold_stage  = 0;
    int                  cycle_count = 0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus two long hold-offs while the sender keeps
    // offering items, so the block backs up and drops its input ready.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready = 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready = 1'b0;
        end
        else if (hold_stage < 2 && items_sent >= ((hold_stage == 0) ? 60 : 720))
        begin
            hold_left = HOLD_LEN;
            hold_stage++;
            rsp_ch.ready = 1'b0;
        end
        else
            rsp_ch.ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_seen.status       = rsp_ch.status;
            rsp_seen.abs_lba      = rsp_ch.abs_lba;
            rsp_seen.part_count   = rsp_ch.part_count;
            rsp_seen.is_esp       = rsp_ch.is_esp;
            rsp_seen.is_formatted = rsp_ch.is_formatted;
            rsp_seen.esp_index    = rsp_ch.esp_index;
            sb.check_result(rsp_seen);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic ptt_request_t request_of(req_type_t kind);
        ptt_request_t r;
        r = '0;
        r.req_type = kind;
        return r;
    endfunction

    function automatic ptt_request_t mbr_item(logic [7:0] code, logic [63:0] first,
                                              logic [63:0] count);
        ptt_request_t r;
        r = request_of(REQ_LOAD_MBR);
        r.type_code    = code;
        r.start_lba    = first;
        r.end_or_count = count;
        return r;
    endfunction

    function automatic ptt_request_t gpt_item(logic [63:0] lo, logic [63:0] hi,
                                              logic [63:0] first, logic [63:0] last);
        ptt_request_t r;
        r = request_of(REQ_LOAD_GPT);
        r.guid_low     = lo;
        r.guid_high    = hi;
        r.start_lba    = first;
        r.end_or_count = last;
        return r;
    endfunction

    function automatic ptt_request_t xlate_item(logic [6:0] idx, logic [63:0] sect);
        ptt_request_t r;
        r = request_of(REQ_TRANSLATE);
        r.part_index = idx;
        r.sector     = sect;
        return r;
    endfunction

    function automatic ptt_request_t rand_mbr();
        logic [7:0]  code;
        logic [63:0] first;
        logic [63:0] count;
        case ($urandom_range(0, 9))
            0:       code = MBR_EMPTY;
            1:       code = MBR_ESP;
            2:       code = MBR_NATIVE_FS;
            3:       code = MBR_NTFS;
            4:       code = MBR_FAT32;
            5:       code = MBR_FAT32_LBA;
            default: code = 8'($urandom_range(0, 255));
        endcase
        first = rand64();
        if ($urandom_range(0, 1))
            first[31:0] = $urandom_range(0, 1 << 20);
        count = $urandom_range(0, 1) ? 64'($urandom_range(0, 4096)) : rand64();
        return mbr_item(code, first, count);
    endfunction

    function automatic ptt_request_t rand_gpt();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] first;
        logic [63:0] last;
        lo = rand64();
        hi = rand64();
        case ($urandom_range(0, 9))
            0: begin lo = '0; hi = '0; end
            1: begin lo = ESP_GUID_LO; hi = ESP_GUID_HI; end
            2: begin lo = BDATA_GUID_LO; hi = BDATA_GUID_HI; end
            3: begin lo = NATIVE_FS_GUID_LO; hi = NATIVE_FS_GUID_HI; end
            4: lo = ESP_GUID_LO;
            5: hi = BDATA_GUID_HI;
            6: hi = '0;
            default: ;
        endcase
        first = $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 100000));
        case ($urandom_range(0, 3))
            0:       last = first + 64'($urandom_range(0, 5000));
            1:       last = first;
            2:       last = first - 64'd1;
            default: last = rand64();
        endcase
        return gpt_item(lo, hi, first, last);
    endfunction

    // Mostly addresses stored entries, with sectors around the edges of the span.
    function automatic ptt_request_t rand_xlate();
        logic [6:0]  idx;
        logic [63:0] span;
        logic [63:0] sect;
        if (sb.entries > 0 && $urandom_range(0, 9) < 8)
            idx = 7'($urandom_range(0, sb.entries - 1));
        else
            idx = 7'($urandom_range(0, 127));
        sect = rand64();
        if (int'(idx) < sb.entries)
        begin
            span = sb.last_tab[idx] - sb.first_tab[idx];
            case ($urandom_range(0, 5))
                0: sect = '0;
                1: sect = span;
                2: sect = span + 64'd1;
                3: sect = (span == '1) ? rand64() : rand64() % (span + 64'd1);
                4: sect = 64'($urandom_range(0, 1000));
                default: ;
            endcase
        end
        return xlate_item(idx, sect);
    endfunction

    task automatic send(input ptt_request_t r);
        @(negedge clk);
        if (items_sent < RANDOM_STOP / 3)
        begin
            tx_idle_pct = 18;
            rx_idle_pct = 73;
        end
        else if (items_sent < 2 * RANDOM_STOP / 3)
        begin
            tx_idle_pct = 73;
            rx_idle_pct = 18;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.req_type     = r.req_type;
        req_ch.type_code    = r.type_code;
        req_ch.guid_low     = r.guid_low;
        req_ch.guid_high    = r.guid_high;
        req_ch.start_lba    = r.start_lba;
        req_ch.end_or_count = r.end_or_count;
        req_ch.part_index   = r.part_index;
        req_ch.sector       = r.sector;
        req_ch.valid        = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(r);
        items_sent++;
    endtask

    initial
    begin
        int           episode;
        ptt_request_t r;

        sb = new;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_CLEAR;
        req_ch.type_code    = '0;
        req_ch.guid_low     = '0;
        req_ch.guid_high    = '0;
        req_ch.start_lba    = '0;
        req_ch.end_or_count = '0;
        req_ch.part_index   = '0;
        req_ch.sector       = '0;
        repeat (RESET_LEN) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty table, every type code class, wrapping ends,
        // span edges and indexes at and past the count.
        send(xlate_item(7'd0, 64'd0));
        send(mbr_item(MBR_EMPTY, 64'd5, 64'd10));
        send(gpt_item(64'h0, 64'h0, 64'd1, 64'd2));
        send(mbr_item(MBR_ESP, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20));
        send(mbr_item(MBR_NATIVE_FS, 64'd0, 64'd0));
        send(mbr_item(MBR_NTFS, 64'd100, 64'd1));
        send(mbr_item(MBR_FAT32, 64'd2048, 64'd4096));
        send(mbr_item(MBR_FAT32_LBA, 64'hABCD_0000_0000_1000, 64'h1234_0000_0000_0010));
        send(mbr_item(8'hFF, 64'hFFFF_FFFF, '1));
        send(gpt_item(ESP_GUID_LO, ESP_GUID_HI, 64'd34, 64'd1_000_000));
        send(gpt_item(BDATA_GUID_LO, BDATA_GUID_HI, '1, '1));
        send(gpt_item(NATIVE_FS_GUID_LO, NATIVE_FS_GUID_HI, 64'd0, 64'd0));
        send(gpt_item(ESP_GUID_LO, 64'h1, 64'd10, 64'd20));
        send(gpt_item(64'h0, '1, 64'hFFFF_FFFF_FFFF_FFF0, 64'h10));
        send(xlate_item(7'd2, 64'd0));
        send(xlate_item(7'd2, 64'd1));
        send(xlate_item(7'd13, 64'h20));
        send(xlate_item(7'd13, 64'h21));
        send(xlate_item(7'd14, 64'd0));
        send(xlate_item(7'd127, 64'd0));
        send(xlate_item(7'd1, 64'hFFFF_FFFF));
        send(xlate_item(7'd0, '1));
        send(request_of(REQ_CLEAR));
        send(mbr_item(MBR_ESP, 64'd63, 64'd100));
        send(xlate_item(7'd0, 64'd5));

        // Random part: well-formed episodes of loads then translates; the first
        // episode and a few later ones fill the table past its capacity.
        episode = 0;
        while (items_sent < RANDOM_STOP)
        begin
            if (episode == 0 || $urandom_range(0, 9) == 0)
            begin
                send(request_of(REQ_CLEAR));
                while (sb.entries < MAX_PARTS)
                    send($urandom_range(0, 1) ? rand_mbr() : rand_gpt());
                send(mbr_item(MBR_NTFS, rand64(), rand64()));
                repeat ($urandom_range(1, 3))
                    send($urandom_range(0, 1) ? rand_mbr() : rand_gpt());
                repeat (10)
                    send(rand_xlate());
            end
            else
            begin
                if ($urandom_range(0, 2) == 0)
                    send(request_of(REQ_CLEAR));
                repeat ($urandom_range(1, 10))
                    send($urandom_range(0, 1) ? rand_mbr() : rand_gpt());
                repeat ($urandom_range(2, 10))
                    send(rand_xlate());
                if ($urandom_range(0, 1))
                begin
                    r.req_type     = req_type_t'($urandom_range(0, 3));
                    r.type_code    = 8'($urandom_range(0, 255));
                    r.guid_low     = rand64();
                    r.guid_high    = rand64();
                    r.start_lba    = rand64();
                    r.end_or_count = rand64();
                    r.part_index   = 7'($urandom_range(0, 127));
                    r.sector       = rand64();
                    send(r);
                end
            end
            episode++;
        end

        @(negedge clk);
        req_ch.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== partition_table_translate_top.f =====
src/ptt_pkg.sv
src/ptt_req_if.sv
src/ptt_rsp_if.sv
src/ptt_classify.sv
src/partition_table_translate_top.sv
tb/partition_table_translate_top_tb.sv
